FILE: hw/rtl/siph_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siph_pkg: shared types, constants and round functions
// Lane state, finalization pipeline payload and the SipHash ARX round used
// by the absorb loop and the finalization pipeline.
// ----------------------------------------------------------------------------
package siph_pkg;

  // Initialization constants for the four lanes.
  localparam logic [63:0] INIT_A = 64'h736f6d6570736575;
  localparam logic [63:0] INIT_B = 64'h646f72616e646f6d;
  localparam logic [63:0] INIT_C = 64'h6c7967656e657261;
  localparam logic [63:0] INIT_D = 64'h7465646279746573;

  // Domain tweaks for the wide and narrow digests.
  localparam logic [63:0] TWEAK_WIDE   = 64'h00000000000000ee;
  localparam logic [63:0] TWEAK_NARROW = 64'h00000000000000ff;
  localparam logic [63:0] TWEAK_SECOND = 64'h00000000000000dd;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_WIDE     = 2'd2;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    logic [63:0] d;
  } lanes_t;

  // One entry of the finalization pipeline.
  typedef struct packed {
    lanes_t      lanes;
    logic [63:0] msg;
    logic [63:0] h0;
    logic        wide;
  } fin_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  // One SipRound.
  function automatic lanes_t sip_round(input lanes_t l);
    lanes_t v;
    v = l;
    v.a = v.a + v.b; v.b = rotl(v.b, 13); v.b = v.b ^ v.a; v.a = rotl(v.a, 32);
    v.c = v.c + v.d; v.d = rotl(v.d, 16); v.d = v.d ^ v.c;
    v.a = v.a + v.d; v.d = rotl(v.d, 21); v.d = v.d ^ v.a;
    v.c = v.c + v.b; v.b = rotl(v.b, 17); v.b = v.b ^ v.c; v.c = rotl(v.c, 32);
    return v;
  endfunction

  // Absorb one message word with n compression rounds (n at most 8).
  function automatic lanes_t absorb(input lanes_t l, input logic [63:0] m, input int n);
    lanes_t v;
    v = l;
    v.d = v.d ^ m;
    for (int i = 0; i < 8; i++) begin
      if (i < n) begin
        v = sip_round(v);
      end
    end
    v.a = v.a ^ m;
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/siph_final.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siph_final: tail absorb and finalization pipeline
// One SipRound per stage: the padded tail, then the first and second
// finalization passes, ending in the digest output register.
// ----------------------------------------------------------------------------
module siph_final
  import siph_pkg::*;
#(
  parameter int COMPRESS_ROUNDS = 2,
  parameter int FINAL_ROUNDS    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        entry_valid,
  input  wire fin_t        entry,
  output      logic        entry_ready,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] hash_low,
  output      logic [63:0] hash_high
);

  localparam int NSTAGE = COMPRESS_ROUNDS + 2 * FINAL_ROUNDS;

  fin_t              stage_r [NSTAGE];
  logic [NSTAGE-1:0] vld_r;
  fin_t              stage_nxt [NSTAGE];
  logic [NSTAGE:0]   rdy;
  logic              out_vld_r;
  logic [63:0]       hash_low_r;
  logic [63:0]       hash_high_r;

  // Per-stage work: pre-round tweaks at fixed stage positions, then one round.
  for (genvar j = 0; j < NSTAGE; j++) begin : g_stage
    always_comb begin
      fin_t t;
      t = stage_r[j];
      if (j == 0) begin
        t.lanes.d = t.lanes.d ^ t.msg;
      end
      if (j == COMPRESS_ROUNDS) begin
        t.lanes.a = t.lanes.a ^ t.msg;
        t.lanes.c = t.lanes.c ^ (t.wide ? TWEAK_WIDE : TWEAK_NARROW);
      end
      if (j == COMPRESS_ROUNDS + FINAL_ROUNDS) begin
        t.h0 = t.lanes.a ^ t.lanes.b ^ t.lanes.c ^ t.lanes.d;
        if (t.wide) begin
          t.lanes.b = t.lanes.b ^ TWEAK_SECOND;
        end
      end
      t.lanes = sip_round(t.lanes);
      stage_nxt[j] = t;
    end
  end

  // A stage takes new data when it is empty or its successor takes its data.
  always_comb begin
    rdy[NSTAGE] = !out_vld_r || !out_stall;
    for (int j = NSTAGE - 1; j >= 0; j--) begin
      rdy[j] = !vld_r[j] || rdy[j+1];
    end
  end

  assign entry_ready = rdy[0];

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      for (int j = 0; j < NSTAGE; j++) begin
        if (rdy[j]) begin
          vld_r[j] <= (j == 0) ? entry_valid : vld_r[(j == 0) ? 0 : j - 1];
        end
      end
      if (rdy[NSTAGE]) begin
        out_vld_r <= vld_r[NSTAGE-1];
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      stage_r[0] <= entry;
    end
    for (int j = 1; j < NSTAGE; j++) begin
      if (rdy[j]) begin
        stage_r[j] <= stage_nxt[j-1];
      end
    end
    if (rdy[NSTAGE]) begin
      hash_low_r  <= stage_nxt[NSTAGE-1].h0;
      hash_high_r <= stage_nxt[NSTAGE-1].wide ?
                     (stage_nxt[NSTAGE-1].lanes.a ^ stage_nxt[NSTAGE-1].lanes.b ^
                      stage_nxt[NSTAGE-1].lanes.c ^ stage_nxt[NSTAGE-1].lanes.d) : 64'd0;
    end
  end

  assign out_valid = out_vld_r;
  assign hash_low  = hash_low_r;
  assign hash_high = hash_high_r;

  // A finished digest in the last stage is never dropped while the output is blocked.
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[NSTAGE-1] && !rdy[NSTAGE] |=> vld_r[NSTAGE-1])
    else $error("last stage lost a digest while blocked");

  // With the output register empty the whole pipeline can move.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> entry_ready)
    else $error("pipeline blocked with empty output register");

  // A blocked output register keeps its digest.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_stall |=> out_vld_r && $stable(hash_low_r))
    else $error("stalled digest changed");

endmodule
`default_nettype wire

FILE: hw/rtl/siphash_keyed_hash.sv
`default_nettype none
// ----------------------------------------------------------------------------
// siphash_keyed_hash: keyed SipHash-2-4 engine
// Absorbs little-endian 64-bit message words and returns a 64-bit or
// 128-bit digest for each message.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one message word per transfer with
//   its byte count and a last flag. Words that are not last always absorb
//   eight bytes; the last word carries 0 to 8 bytes.
//   Output channel (out_valid / out_stall): one digest per message. out_valid
//   rises once the last word has passed through every tail and finalization
//   stage and into the output register.
//   Throughput: one word per cycle while in_stall is low. The absorb loop runs
//   all compression rounds for a word combinationally; the tail and
//   finalization rounds run in a pipeline of one round per stage, so messages
//   follow each other without gaps.
//   Stall: a stalled digest holds in the output register while the pipeline
//   keeps filling; in_stall rises only once every stage holds a digest.
//   Configuration: key_low at 0x00, key_high at 0x08, wide_output at 0x10.
//   Write only while the engine is idle. The key is taken at the first word
//   of a message; wide_output at the first and at the last word.
//   Reset: clears the registers, the message length and the pipeline.
// ----------------------------------------------------------------------------
module siphash_keyed_hash
  import siph_pkg::*;
#(
  parameter int COMPRESS_ROUNDS = 2,
  parameter int FINAL_ROUNDS    = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output      logic [63:0] prdata,
  output      logic        pready,
  // Input channel
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [63:0] in_data_word,
  input  wire logic [3:0]  in_byte_count,
  input  wire logic        in_last,
  // Result channel
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [63:0] out_hash_low,
  output      logic [63:0] out_hash_high
);

  logic [63:0] key_low_r;
  logic [63:0] key_high_r;
  logic        wide_r;
  lanes_t      lanes_r;
  logic [7:0]  len_r;
  logic        mid_r;

  logic        cfg_wr;
  logic [1:0]  reg_idx;
  logic        in_xfer;
  logic        entry_ready;
  lanes_t      init_lanes;
  lanes_t      cur_lanes;
  lanes_t      lanes_nxt;
  logic [7:0]  len_base;
  logic [7:0]  len_nxt;
  logic [3:0]  cnt;
  logic        full_word;
  logic [63:0] masked;
  fin_t        entry;

  // Configuration registers.
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
      wide_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KEY_LOW:  key_low_r  <= pwdata;
        REG_KEY_HIGH: key_high_r <= pwdata;
        REG_WIDE:     wide_r     <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KEY_LOW:  prdata = key_low_r;
      REG_KEY_HIGH: prdata = key_high_r;
      REG_WIDE:     prdata = {63'd0, wide_r};
      default:      prdata = 64'd0;
    endcase
  end

  // Lane values at message start.
  always_comb begin
    init_lanes.a = INIT_A ^ key_low_r;
    init_lanes.b = INIT_B ^ key_high_r ^ (wide_r ? TWEAK_WIDE : 64'd0);
    init_lanes.c = INIT_C ^ key_low_r;
    init_lanes.d = INIT_D ^ key_high_r;
  end

  // Absorb loop: all compression rounds of one word, computed combinationally.
  always_comb begin
    cur_lanes = mid_r ? lanes_r : init_lanes;
    len_base  = mid_r ? len_r : 8'd0;
    cnt       = (in_byte_count > 4'd8) ? 4'd8 : in_byte_count;
    full_word = !in_last || (cnt == 4'd8);
    lanes_nxt = full_word ? absorb(cur_lanes, in_data_word, COMPRESS_ROUNDS) : cur_lanes;
    len_nxt   = len_base + (full_word ? 8'd8 : {4'd0, cnt});
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < cnt) ? in_data_word[8*b +: 8] : 8'h00;
    end
    entry.lanes = lanes_nxt;
    entry.msg   = full_word ? {len_nxt, 56'd0} : {len_nxt, masked[55:0]};
    entry.h0    = 64'd0;
    entry.wide  = wide_r;
  end

  assign in_stall = !entry_ready;
  assign in_xfer  = in_valid && !in_stall;

  // Message state between words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      mid_r <= 1'b0;
    end else if (in_xfer) begin
      len_r <= len_nxt;
      mid_r <= !in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && !in_last) begin
      lanes_r <= lanes_nxt;
    end
  end

  siph_final #(
    .COMPRESS_ROUNDS (COMPRESS_ROUNDS),
    .FINAL_ROUNDS    (FINAL_ROUNDS)
  ) u_final (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (in_xfer && in_last),
    .entry       (entry),
    .entry_ready (entry_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hash_low    (out_hash_low),
    .hash_high   (out_hash_high)
  );

  // A last word closes the message; any other word keeps it open.
  a_mid_state: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (mid_r == !$past(in_last)))
    else $error("message state wrong after transfer");

  // A word that is not last adds eight bytes to the running length.
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !in_last |=> len_r == 8'($past(len_base) + 8'd8))
    else $error("length did not advance by eight");

  // A write to the width register lands in it.
  a_wide_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && (reg_idx == REG_WIDE) |=> wide_r == $past(pwdata[0]))
    else $error("width register write lost");

endmodule
`default_nettype wire
